// ----- sv/sea_pkg.sv -----
// Shared types and constants for the symbol entry allocator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sea_pkg;

    localparam int OPCODE_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 31;
    localparam int REF_W      = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_NT  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_VALUE_MAX = 1'b1;

    localparam logic [CFG_W-1:0] FIRST_NT_RESET  = 31'd256;
    localparam logic [CFG_W-1:0] VALUE_MAX_RESET = 31'h7FFF_FFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_NOTHING   = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   entry_index;
    } t_result;

    typedef struct packed {
        logic link_rd;
        logic link_wr;
        logic ref_rd;
        logic ref_wr;
        logic ent_wr;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ----- sv/sea_regs.sv -----
// Configuration registers of the allocator behind an APB-style port.
// Depends on sea_pkg.
`default_nettype none

module sea_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sea_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [sea_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [sea_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [sea_pkg::CFG_W-1:0]        o_first_nt,
    output logic      [sea_pkg::CFG_W-1:0]        o_value_max
);
    import sea_pkg::*;

    logic [CFG_W-1:0]     r_first_nt;
    logic [CFG_W-1:0]     r_value_max;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_nt  <= FIRST_NT_RESET;
            r_value_max <= VALUE_MAX_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FIRST_NT:  r_first_nt  <= pwdata[CFG_W-1:0];
                REG_VALUE_MAX: r_value_max <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FIRST_NT:  prdata = APB_DATA_W'(r_first_nt);
            REG_VALUE_MAX: prdata = APB_DATA_W'(r_value_max);
            default:       prdata = '0;
        endcase
    end

    assign o_first_nt  = r_first_nt;
    assign o_value_max = r_value_max;

endmodule

`default_nettype wire

// ----- sv/sea_store.sv -----
// Entry store: link, refcount, value and rule memories; link and refcount reads are registered.
// Depends on sea_pkg.
`default_nettype none

module sea_store #(
    parameter int NUM_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                              i_clk,
    input  wire sea_pkg::t_mem_ctl                 i_ctl,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]    i_link_raddr,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]    i_link_waddr,
    input  wire logic [$clog2(NUM_ENTRIES):0]      i_link_wdata,
    output logic      [$clog2(NUM_ENTRIES):0]      o_link_rdata,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]    i_ref_raddr,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]    i_ref_waddr,
    input  wire logic [sea_pkg::REF_W-1:0]         i_ref_wdata,
    output logic      [sea_pkg::REF_W-1:0]         o_ref_rdata,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]    i_ent_addr,
    input  wire logic [VALUE_BITS-1:0]             i_ent_value,
    input  wire logic [$clog2(NUM_ENTRIES):0]      i_ent_rule
);
    import sea_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int PW = IW + 1;

    logic [PW-1:0]         r_link_mem  [NUM_ENTRIES];
    logic [REF_W-1:0]      r_ref_mem   [NUM_ENTRIES];
    logic [VALUE_BITS-1:0] r_value_mem [NUM_ENTRIES];
    logic [PW-1:0]         r_rule_mem  [NUM_ENTRIES];
    logic [PW-1:0]         r_link_q;
    logic [REF_W-1:0]      r_ref_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_rd) begin
            r_link_q <= r_link_mem[i_link_raddr];
        end
        if (i_ctl.link_wr) begin
            r_link_mem[i_link_waddr] <= i_link_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ref_rd) begin
            r_ref_q <= r_ref_mem[i_ref_raddr];
        end
        if (i_ctl.ref_wr) begin
            r_ref_mem[i_ref_waddr] <= i_ref_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_wr) begin
            r_value_mem[i_ent_addr] <= i_ent_value;
            r_rule_mem[i_ent_addr]  <= i_ent_rule;
        end
    end

    assign o_link_rdata = r_link_q;
    assign o_ref_rdata  = r_ref_q;

endmodule

`default_nettype wire

// ----- sv/sea_ctrl.sv -----
// Allocation sequencer: range checks, free list head, bump pointer and
// rule refcount update. Depends on sea_pkg; drives sea_store.
`default_nettype none

module sea_ctrl #(
    parameter int NUM_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [sea_pkg::CFG_W-1:0]         i_first_nt,
    input  wire logic [sea_pkg::CFG_W-1:0]         i_value_max,
    input  wire logic                              i_go,
    input  wire logic [sea_pkg::OPCODE_W-1:0]      i_opcode,
    input  wire logic [sea_pkg::VALUE_W-1:0]       i_symbol_value,
    input  wire logic                              i_rule_given,
    input  wire logic [sea_pkg::INDEX_W-1:0]       i_rule_index,
    input  wire logic                              i_free_given,
    input  wire logic [sea_pkg::INDEX_W-1:0]       i_free_index,
    output logic                                   o_busy,
    output sea_pkg::t_result                       o_result,
    output sea_pkg::t_mem_ctl                      o_ctl,
    output logic      [$clog2(NUM_ENTRIES)-1:0]    o_link_raddr,
    output logic      [$clog2(NUM_ENTRIES)-1:0]    o_link_waddr,
    output logic      [$clog2(NUM_ENTRIES):0]      o_link_wdata,
    input  wire logic [$clog2(NUM_ENTRIES):0]      i_link_rdata,
    output logic      [$clog2(NUM_ENTRIES)-1:0]    o_ref_raddr,
    output logic      [$clog2(NUM_ENTRIES)-1:0]    o_ref_waddr,
    output logic      [sea_pkg::REF_W-1:0]         o_ref_wdata,
    input  wire logic [sea_pkg::REF_W-1:0]         i_ref_rdata,
    output logic      [$clog2(NUM_ENTRIES)-1:0]    o_ent_addr,
    output logic      [VALUE_BITS-1:0]             o_ent_value,
    output logic      [$clog2(NUM_ENTRIES):0]      o_ent_rule
);
    import sea_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int PW = IW + 1;
    localparam logic [PW-1:0]      NULL_PTR  = PW'(NUM_ENTRIES);
    localparam logic [VALUE_W-1:0] VALUE_CAP = VALUE_W'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

    typedef enum logic {
        S_IDLE,
        S_FIN
    } t_state;

    t_state        r_state;
    logic [PW-1:0] r_free_head;
    logic [PW-1:0] r_used;
    logic          r_pop;
    logic          r_inc;
    logic [IW-1:0] r_rule;
    logic          r_took;
    logic [IW-1:0] r_slot;

    t_opcode       op;
    logic          is_neg;
    logic          is_term;
    logic          is_nonterm;
    logic          head_ok;
    logic          room;
    logic [IW-1:0] slot;
    logic [IW-1:0] rule_addr;
    logic          rule_hit;
    logic [IW-1:0] free_addr;
    logic          free_ok;
    logic          alloc_ok;
    logic [PW-1:0] link_next;
    logic [REF_W-1:0] ref_inc;

    always_comb begin
        op         = t_opcode'(i_opcode);
        is_neg     = i_symbol_value[VALUE_W-1];
        is_term    = !is_neg && (i_symbol_value[CFG_W-1:0] < i_first_nt);
        is_nonterm = !is_neg && !is_term
                     && (i_symbol_value[CFG_W-1:0] <= i_value_max)
                     && (i_symbol_value <= VALUE_CAP);
        head_ok    = r_free_head < NULL_PTR;
        room       = r_used < NULL_PTR;
        slot       = head_ok ? r_free_head[IW-1:0] : r_used[IW-1:0];
        rule_addr  = IW'(i_rule_index);
        rule_hit   = is_nonterm && i_rule_given
                     && (32'(i_rule_index) < 32'(NUM_ENTRIES));
        free_addr  = IW'(i_free_index);
        free_ok    = i_free_given && (32'(i_free_index) < 32'(NUM_ENTRIES));
        alloc_ok   = i_go && (op == OP_ALLOC) && (is_term || is_nonterm)
                     && (head_ok || room);
        link_next  = (i_link_rdata > NULL_PTR) ? NULL_PTR : i_link_rdata;
        ref_inc    = (i_ref_rdata == '1) ? i_ref_rdata : i_ref_rdata + REF_W'(1);
    end

    always_comb begin
        o_result.entry_index = '0;
        unique case (op)
            OP_ALLOC: begin
                if (!(is_term || is_nonterm)) begin
                    o_result.status = ST_RANGE;
                end else if (!(head_ok || room)) begin
                    o_result.status = ST_EXHAUSTED;
                end else begin
                    o_result.status      = ST_OK;
                    o_result.entry_index = INDEX_W'(slot);
                end
            end
            OP_FREE:  o_result.status = free_ok ? ST_OK : ST_NOTHING;
            OP_CLEAR: o_result.status = ST_OK;
            OP_NOP:   o_result.status = ST_NOTHING;
            default:  o_result.status = ST_NOTHING;
        endcase
    end

    always_comb begin
        o_ctl.link_rd = alloc_ok && head_ok;
        o_ctl.link_wr = (i_go && (op == OP_FREE) && free_ok)
                        || ((r_state == S_FIN) && r_took);
        o_ctl.ref_rd  = alloc_ok && rule_hit;
        o_ctl.ref_wr  = alloc_ok || ((r_state == S_FIN) && r_inc);
        o_ctl.ent_wr  = alloc_ok;
        o_link_raddr  = r_free_head[IW-1:0];
        o_link_waddr  = (r_state == S_FIN) ? r_slot : free_addr;
        o_link_wdata  = (r_state == S_FIN) ? NULL_PTR : r_free_head;
        o_ref_raddr   = rule_addr;
        o_ref_waddr   = (r_state == S_FIN) ? r_rule : slot;
        o_ref_wdata   = (r_state == S_FIN) ? ref_inc : '0;
        o_ent_addr    = slot;
        o_ent_value   = VALUE_BITS'(i_symbol_value);
        o_ent_rule    = rule_hit ? {1'b0, rule_addr} : NULL_PTR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= NULL_PTR;
            r_used      <= '0;
            r_pop       <= 1'b0;
            r_inc       <= 1'b0;
            r_took      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        unique case (op)
                            OP_ALLOC: begin
                                r_state <= S_FIN;
                                r_pop   <= alloc_ok && head_ok;
                                r_inc   <= alloc_ok && rule_hit && (rule_addr != slot);
                                r_rule  <= rule_addr;
                                r_took  <= alloc_ok;
                                r_slot  <= slot;
                                if (alloc_ok && !head_ok) begin
                                    r_used <= r_used + PW'(1);
                                end
                            end
                            OP_FREE: begin
                                if (free_ok) begin
                                    r_free_head <= {1'b0, free_addr};
                                end
                            end
                            OP_CLEAR: begin
                                r_free_head <= NULL_PTR;
                                r_used      <= '0;
                            end
                            OP_NOP: ;
                            default: ;
                        endcase
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    if (r_pop) begin
                        r_free_head <= link_next;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state == S_FIN);

endmodule

`default_nettype wire

// ----- sv/sea_obuf.sv -----
// Two-entry result buffer (output register plus skid register).
// Depends on sea_pkg.
`default_nettype none

module sea_obuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sea_pkg::t_result  i_result,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output sea_pkg::t_result       o_result,
    output logic                   o_skid_full
);
    import sea_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end else if (i_push) begin
                r_out <= i_result;
            end else begin
                r_out_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld) begin
                r_out     <= i_result;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= i_result;
                r_skid_vld <= 1'b1;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_result    = r_out;
    assign o_skid_full = r_skid_vld;

endmodule

`default_nettype wire

// ----- sv/symbol_entry_allocator_top.sv -----
// Symbol entry allocator: a free list of entries chained through link words,
// backed by a bump pointer, with per-entry reference counts.
// Instantiates sea_regs, sea_ctrl, sea_store and sea_obuf; depends on sea_pkg.
//
// Each transaction on the input channel carries one operation: allocate, free,
// clear or no-op. Each produces exactly one result transaction carrying a
// status and, for a successful allocate, the entry index.
// The result is registered at the edge that accepts the transaction. Free,
// clear and no-op complete in S_IDLE; an allocate also passes through S_FIN,
// as the free list head's link word and the named rule entry's refcount are
// read from memory on acceptance and loaded into the head pointer or written
// back in S_FIN. A stalled result waits in the output register; one more
// result can be taken into a skid register, after which the input stalls
// until the output drains. Reset empties the free list, zeroes the bump
// pointer and loads the register defaults; the memories need no clearing
// pass. The user must write configuration through the APB port only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module symbol_entry_allocator_top #(
    parameter int NUM_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sea_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [sea_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [sea_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [sea_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire logic [sea_pkg::VALUE_W-1:0]      i_symbol_value,
    input  wire logic                             i_rule_given,
    input  wire logic [sea_pkg::INDEX_W-1:0]      i_rule_index,
    input  wire logic                             i_free_given,
    input  wire logic [sea_pkg::INDEX_W-1:0]      i_free_index,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [sea_pkg::STATUS_W-1:0]     o_status,
    output logic      [sea_pkg::INDEX_W-1:0]      o_entry_index
);
    import sea_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int PW = IW + 1;

    logic [CFG_W-1:0]      first_nt;
    logic [CFG_W-1:0]      value_max;
    logic                  busy;
    logic                  skid_full;
    logic                  go;
    t_result               result;
    t_result               out_result;
    t_mem_ctl              mem_ctl;
    logic [IW-1:0]         link_raddr;
    logic [IW-1:0]         link_waddr;
    logic [PW-1:0]         link_wdata;
    logic [PW-1:0]         link_rdata;
    logic [IW-1:0]         ref_raddr;
    logic [IW-1:0]         ref_waddr;
    logic [REF_W-1:0]      ref_wdata;
    logic [REF_W-1:0]      ref_rdata;
    logic [IW-1:0]         ent_addr;
    logic [VALUE_BITS-1:0] ent_value;
    logic [PW-1:0]         ent_rule;

    assign o_in_stall = busy || skid_full;
    assign go         = i_in_valid && !o_in_stall;

    sea_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_first_nt  (first_nt),
        .o_value_max (value_max)
    );

    sea_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_first_nt     (first_nt),
        .i_value_max    (value_max),
        .i_go           (go),
        .i_opcode       (i_opcode),
        .i_symbol_value (i_symbol_value),
        .i_rule_given   (i_rule_given),
        .i_rule_index   (i_rule_index),
        .i_free_given   (i_free_given),
        .i_free_index   (i_free_index),
        .o_busy         (busy),
        .o_result       (result),
        .o_ctl          (mem_ctl),
        .o_link_raddr   (link_raddr),
        .o_link_waddr   (link_waddr),
        .o_link_wdata   (link_wdata),
        .i_link_rdata   (link_rdata),
        .o_ref_raddr    (ref_raddr),
        .o_ref_waddr    (ref_waddr),
        .o_ref_wdata    (ref_wdata),
        .i_ref_rdata    (ref_rdata),
        .o_ent_addr     (ent_addr),
        .o_ent_value    (ent_value),
        .o_ent_rule     (ent_rule)
    );

    sea_store #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_link_raddr (link_raddr),
        .i_link_waddr (link_waddr),
        .i_link_wdata (link_wdata),
        .o_link_rdata (link_rdata),
        .i_ref_raddr  (ref_raddr),
        .i_ref_waddr  (ref_waddr),
        .i_ref_wdata  (ref_wdata),
        .o_ref_rdata  (ref_rdata),
        .i_ent_addr   (ent_addr),
        .i_ent_value  (ent_value),
        .i_ent_rule   (ent_rule)
    );

    sea_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (go),
        .i_result    (result),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_result    (out_result),
        .o_skid_full (skid_full)
    );

    assign o_status      = out_result.status;
    assign o_entry_index = out_result.entry_index;

endmodule

`default_nettype wire

// ----- sv/sea_checker.sv -----
// Port-level assertions for the symbol entry allocator and their bind.
// Depends on sea_pkg and symbol_entry_allocator_top.
`default_nettype none

module sea_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic [sea_pkg::OPCODE_W-1:0]    i_opcode,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [sea_pkg::STATUS_W-1:0]    o_status,
    input wire logic [sea_pkg::INDEX_W-1:0]     o_entry_index
);
    import sea_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_alloc_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_opcode == OP_ALLOC) |=> o_in_stall)
        else $error("allocate transaction did not hold off the next one");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted transaction left no result on the output");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_entry_index == '0))
        else $error("failed result carries a nonzero entry index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_entry_index))
        else $error("stalled result changed");

endmodule

bind symbol_entry_allocator_top sea_checker u_sea_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_entry_index (o_entry_index)
);

`default_nettype wire
